/* sv/positional_list_engine_defines.svh */
// Assertion macros shared by the list engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ple_pkg.sv */
// Types, codes and sizes for the positional list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    typedef logic [2:0]        t_kind;
    typedef logic [2:0]        t_status;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic signed [31:0] t_word;

    localparam t_cnt CAP_CNT = CNT_W'(CAPACITY);

    localparam t_kind K_INS_FRONT = 3'd0;
    localparam t_kind K_INS_BACK  = 3'd1;
    localparam t_kind K_INS_AT    = 3'd2;
    localparam t_kind K_DEL_FRONT = 3'd3;
    localparam t_kind K_DEL_BACK  = 3'd4;
    localparam t_kind K_DEL_AT    = 3'd5;
    localparam t_kind K_SEARCH    = 3'd6;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_INVALID  = 3'd2;
    localparam t_status ST_RANGE    = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;
    localparam t_status ST_FULL     = 3'd5;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* sv/ple_step.sv */
// Shared cursor step and compare unit of the list engine.
// Depends on ple_pkg.
`default_nettype none

module ple_step (
    input  ple_pkg::t_cnt  i_cursor,
    input  ple_pkg::t_cnt  i_limit,
    input  logic           i_dec,
    input  ple_pkg::t_word i_a,
    input  ple_pkg::t_word i_b,
    output ple_pkg::t_cnt  o_next,
    output logic           o_hit,
    output logic           o_eq
);
    import ple_pkg::*;

    assign o_next = i_dec ? (i_cursor - t_cnt'(1)) : (i_cursor + t_cnt'(1));
    assign o_hit  = (i_cursor == i_limit);
    assign o_eq   = (i_a == i_b);

endmodule

`default_nettype wire

/* sv/ple_store.sv */
// Entry store: one write port, one read port with registered read data.
// Depends on ple_pkg.
`default_nettype none

module ple_store (
    input  logic              i_clk,
    input  ple_pkg::t_mem_req i_req,
    output ple_pkg::t_word    o_rdata
);
    import ple_pkg::*;

    t_word r_mem [CAPACITY];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/ple_seq.sv */
// Request decode and walk sequencer of the list engine; drives the store
// and uses one ple_step unit. Depends on ple_pkg and the assertion macros.
`default_nettype none
`include "positional_list_engine_defines.svh"

module ple_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ple_pkg::t_kind    i_kind,
    input  ple_pkg::t_word    i_value,
    input  ple_pkg::t_cnt     i_position,
    input  ple_pkg::t_word    i_rdata,
    output ple_pkg::t_mem_req o_req,
    output logic              o_busy,
    output logic              o_done,
    output ple_pkg::t_status  o_status,
    output ple_pkg::t_cnt     o_found,
    output ple_pkg::t_cnt     o_count
);
    import ple_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UP     = 4'b0010,
        S_DOWN   = 4'b0100,
        S_SEARCH = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_cnt     r_count, n_count;
    logic     r_pend,  n_pend;
    logic     r_done,  n_done;
    t_cnt     r_idx,   n_idx;
    t_cnt     r_target, n_target;
    t_addr    r_lag,   n_lag;
    t_addr    r_waddr, n_waddr;
    t_word    r_value, n_value;
    t_status  r_status, n_status;
    t_cnt     r_found, n_found;
    t_mem_req w_req;

    t_cnt     w_next;
    logic     w_hit;
    logic     w_eq;
    logic     w_full;
    logic     w_empty;
    logic [CNT_W:0] w_cnt_p1;

    ple_step u_step (
        .i_cursor (r_idx),
        .i_limit  ((r_state == S_UP) ? r_target : r_count),
        .i_dec    (r_state == S_UP),
        .i_a      (i_rdata),
        .i_b      (r_value),
        .o_next   (w_next),
        .o_hit    (w_hit),
        .o_eq     (w_eq)
    );

    assign w_full   = (r_count == CAP_CNT);
    assign w_empty  = (r_count == '0);
    assign w_cnt_p1 = {1'b0, r_count} + (CNT_W+1)'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pend   = r_pend;
        n_done   = 1'b0;
        n_idx    = r_idx;
        n_target = r_target;
        n_lag    = r_lag;
        n_waddr  = r_waddr;
        n_value  = r_value;
        n_status = r_status;
        n_found  = r_found;
        w_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    // a request that needs no walk reports at once
                    n_value  = i_value;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_pend   = 1'b0;
                    unique case (i_kind)
                        K_INS_FRONT, K_INS_BACK: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_done   = 1'b0;
                                n_state  = S_UP;
                                n_idx    = r_count;
                                n_target = (i_kind == K_INS_BACK) ? r_count : '0;
                            end
                        end
                        K_INS_AT: begin
                            if (i_position == '0) begin
                                n_status = ST_INVALID;
                            end else if (i_position != t_cnt'(1) && w_empty) begin
                                n_status = ST_EMPTY;
                            end else if ({1'b0, i_position} > w_cnt_p1) begin
                                n_status = ST_RANGE;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_done   = 1'b0;
                                n_state  = S_UP;
                                n_idx    = r_count;
                                n_target = i_position - t_cnt'(1);
                            end
                        end
                        K_DEL_FRONT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_DOWN;
                                n_idx   = t_cnt'(1);
                                n_lag   = '0;
                            end
                        end
                        K_DEL_BACK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - t_cnt'(1);
                            end
                        end
                        K_DEL_AT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (i_position == '0) begin
                                n_status = ST_INVALID;
                            end else if (i_position > r_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_DOWN;
                                n_idx   = i_position;
                                n_lag   = ADDR_W'(i_position - t_cnt'(1));
                            end
                        end
                        K_SEARCH: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SEARCH;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_UP: begin
                // move entry cursor-1 to cursor, walking toward the target
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_waddr;
                    w_req.wdata = i_rdata;
                end
                if (!w_hit) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = w_next[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_waddr     = r_idx[ADDR_W-1:0];
                    n_idx       = w_next;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = r_target[ADDR_W-1:0];
                        w_req.wdata = r_value;
                        n_count     = r_count + t_cnt'(1);
                        n_done      = 1'b1;
                        n_status    = ST_OK;
                        n_found     = '0;
                        n_state     = S_IDLE;
                    end
                end
            end

            S_DOWN: begin
                // move entry cursor to cursor-1 until the back is reached
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_waddr;
                    w_req.wdata = i_rdata;
                end
                if (!w_hit) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_idx[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_waddr     = r_lag;
                    n_lag       = r_idx[ADDR_W-1:0];
                    n_idx       = w_next;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - t_cnt'(1);
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_found  = '0;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_SEARCH: begin
                // read data in hand belongs to entry r_idx-1
                if (r_pend && w_eq) begin
                    n_pend   = 1'b0;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_found  = r_idx;
                    n_state  = S_IDLE;
                end else if (!w_hit) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_idx[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_idx       = w_next;
                end else begin
                    n_pend   = 1'b0;
                    n_done   = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_found  = '0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_target <= n_target;
        r_lag    <= n_lag;
        r_waddr  <= n_waddr;
        r_value  <= n_value;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_req    = w_req;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_count  = r_count;

    `PLE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT, "count above capacity")
    `PLE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "result while busy")
    `PLE_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, r_done && r_found != '0, r_status == ST_OK && r_found <= r_count, "bad found position")
    `PLE_ASSERT_NXT(a_count_step, i_clk, i_rst_n, r_count != CAP_CNT + t_cnt'(1), r_count == $past(r_count) || (r_done && (r_count == $past(r_count) + t_cnt'(1) || r_count == $past(r_count) - t_cnt'(1))), "count moved without a result")

endmodule

`default_nettype wire

/* sv/positional_list_engine.sv */
// Top level of the positional list engine: sequencer plus entry store.
// Depends on ple_pkg, ple_step, ple_store and ple_seq.
//
// Use: drive i_kind, i_value and i_position and raise start while busy is
// low; the item is taken at that clock edge. Exactly one result follows,
// shown for one cycle with o_done high: o_status, o_found_position and
// o_count (entries held after the request). The receiver cannot stall.
// Rejected requests, unused kinds and delete back report on the cycle
// after acceptance and keep busy low, so such items may follow each cycle.
// Walking requests raise busy; one entry is moved or compared per cycle
// through the store's single read and write port. An insert at index k
// moves the entries from k up by one and then writes the value at k; a
// delete at index k moves the entries above k down by one; a search
// compares entries from the front and stops at the first match or after
// the last entry. Reset empties the list at once; no clearing pass is
// needed since only entries below the count are ever read.
`default_nettype none

module positional_list_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ple_pkg::t_kind   i_kind,
    input  ple_pkg::t_word   i_value,
    input  ple_pkg::t_cnt    i_position,
    output logic             busy,
    output logic             o_done,
    output ple_pkg::t_status o_status,
    output ple_pkg::t_cnt    o_found_position,
    output ple_pkg::t_cnt    o_count
);
    import ple_pkg::*;

    t_mem_req w_req;
    t_word    w_rdata;

    ple_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_position (i_position),
        .i_rdata    (w_rdata),
        .o_req      (w_req),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_found    (o_found_position),
        .o_count    (o_count)
    );

    ple_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire
